/* sv/csvtok_pkg.sv */
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Shared character codes, token kinds and the tokenizer state record.
// ----------------------------------------------------------------------------
package csvtok_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned KindW = 2;

    localparam logic [ByteW-1:0] CH_QUOTE = 8'h22;
    localparam logic [ByteW-1:0] CH_COMMA = 8'h2C;
    localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
    localparam logic [ByteW-1:0] CH_CR    = 8'h0D;

    typedef enum logic [KindW-1:0] {
        KIND_DATA      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2,
        KIND_ERROR     = 2'd3
    } t_kind;

    // Tokenizer flags, all cleared by reset and by the end marker.
    typedef struct packed {
        logic inside_quotes;
        logic quote_pending;
        logic quote_closed;
        logic field_has_data;
        logic row_open;
        logic skip_line_feed;
        logic error_latched;
    } t_state;

    // Token produced by one input beat.
    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [ByteW-1:0] data;
    } t_token;

endpackage

/* sv/csvtok_step.sv */
// ----------------------------------------------------------------------------
// CSV tokenizer step logic
// Combinational next-state and token decode for one input beat.
// ----------------------------------------------------------------------------
module csvtok_step
    import csvtok_pkg::*;
(
    input  t_state           i_state,
    input  logic [ByteW-1:0] i_byte,
    input  logic             i_end,
    output t_state           o_state,
    output t_token           o_token
);

    always_comb begin
        t_state nx;
        t_token tk;
        logic   go_unquoted;
        logic   qc;

        nx          = i_state;
        tk          = '{valid: 1'b0, kind: KIND_DATA, data: '0};
        go_unquoted = 1'b0;
        qc          = i_state.quote_closed;

        if (i_end) begin
            // A pending quote at the end closes the field, so only an open
            // quote without a pending close is an unterminated field.
            if (!i_state.error_latched) begin
                if (i_state.inside_quotes && !i_state.quote_pending) begin
                    tk.valid = 1'b1;
                    tk.kind  = KIND_ERROR;
                end else if (i_state.row_open || i_state.field_has_data ||
                             i_state.quote_pending) begin
                    tk.valid = 1'b1;
                    tk.kind  = KIND_ROW_END;
                end
            end
            nx = '0;
        end else if (i_state.error_latched) begin
            nx = i_state;
        end else if (i_state.skip_line_feed && (i_byte == CH_LF)) begin
            nx.skip_line_feed = 1'b0;
        end else begin
            nx.skip_line_feed = 1'b0;
            if (i_state.quote_pending) begin
                nx.quote_pending = 1'b0;
                if (i_byte == CH_QUOTE) begin
                    nx.field_has_data = 1'b1;
                    tk.valid = 1'b1;
                    tk.kind  = KIND_DATA;
                    tk.data  = CH_QUOTE;
                end else begin
                    nx.inside_quotes = 1'b0;
                    nx.quote_closed  = 1'b1;
                    qc               = 1'b1;
                    go_unquoted      = 1'b1;
                end
            end else if (i_state.inside_quotes) begin
                if (i_byte == CH_QUOTE) begin
                    nx.quote_pending = 1'b1;
                end else begin
                    nx.field_has_data = 1'b1;
                    tk.valid = 1'b1;
                    tk.kind  = KIND_DATA;
                    tk.data  = i_byte;
                end
            end else begin
                go_unquoted = 1'b1;
            end

            if (go_unquoted) begin
                if (i_byte == CH_QUOTE) begin
                    if (i_state.field_has_data || qc) begin
                        nx.error_latched = 1'b1;
                        tk.valid = 1'b1;
                        tk.kind  = KIND_ERROR;
                    end else begin
                        nx.inside_quotes = 1'b1;
                        nx.row_open      = 1'b1;
                    end
                end else if (i_byte == CH_COMMA) begin
                    nx.field_has_data = 1'b0;
                    nx.quote_closed   = 1'b0;
                    nx.row_open       = 1'b1;
                    tk.valid = 1'b1;
                    tk.kind  = KIND_FIELD_END;
                end else if ((i_byte == CH_LF) || (i_byte == CH_CR)) begin
                    nx.skip_line_feed = (i_byte == CH_CR);
                    nx.field_has_data = 1'b0;
                    nx.quote_closed   = 1'b0;
                    nx.row_open       = 1'b0;
                    tk.valid = 1'b1;
                    tk.kind  = KIND_ROW_END;
                end else if (qc) begin
                    nx.error_latched = 1'b1;
                    tk.valid = 1'b1;
                    tk.kind  = KIND_ERROR;
                end else begin
                    nx.field_has_data = 1'b1;
                    nx.row_open       = 1'b1;
                    tk.valid = 1'b1;
                    tk.kind  = KIND_DATA;
                    tk.data  = i_byte;
                end
            end
        end

        o_state = nx;
        o_token = tk;
    end

endmodule

/* sv/csv_byte_tokenizer.sv */
// ----------------------------------------------------------------------------
// CSV byte tokenizer
// Streaming CSV tokenizer: one text byte in, at most one token out per beat.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata           tuser
//  -------  ---------  --------------  ------------------
//  s_*      in         [7:0] text byte [0] end of input
//  m_*      out        [7:0] data byte [1:0] token kind
//
// Each input beat is decoded in the same cycle it is accepted; its token,
// if any, appears on the output in the next cycle. The block takes one beat
// per clock, set by the single output register: a new beat is accepted
// whenever that register is empty or is being drained in the same cycle.
// A stall on the output side holds the token and stops input acceptance.
// Synchronous active-low reset clears all tokenizer flags and the output
// valid; an end-of-input beat returns the flags to the same reset state.
//
module csv_byte_tokenizer
    import csvtok_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input stream
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [ByteW-1:0] i_s_tdata,   // [7:0] text_byte
    input  logic             i_s_tuser,   // [0] end_of_input
    // Token stream
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [ByteW-1:0] o_m_tdata,   // [7:0] data_byte
    output logic [KindW-1:0] o_m_tuser    // [1:0] token_kind
);

    t_state           r_state;
    t_state           n_state;
    t_token           n_token;
    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [ByteW-1:0] r_out_data;
    logic             s_accept;

    // The output register can take a new token when it is empty or when its
    // current token leaves in this cycle.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    csvtok_step u_step (
        .i_state (r_state),
        .i_byte  (i_s_tdata),
        .i_end   (i_s_tuser),
        .o_state (n_state),
        .o_token (n_token)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_state     <= n_state;
                r_out_valid <= n_token.valid;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload needs no reset; it is loaded with every accepted beat.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_kind <= n_token.kind;
            r_out_data <= n_token.data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;

endmodule

/* sv/csvtok_checker.sv */
// ----------------------------------------------------------------------------
// CSV tokenizer checker
// Port-level assertions for the CSV byte tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module csvtok_checker
    import csvtok_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [ByteW-1:0] o_m_tdata,
    input logic [KindW-1:0] o_m_tuser
);

    // A stalled token holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("token changed while stalled");

    // Only data tokens carry a character.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != KIND_DATA) |-> (o_m_tdata == '0))
        else $error("non-data token carries a byte");

    // Reset leaves no token on the output.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("token valid after reset");

    // A new token follows an accepted input beat.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready))
        else $error("token appeared without an input beat");

    // An empty output register never holds off the input side.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

endmodule

bind csv_byte_tokenizer csvtok_checker u_csvtok_checker (.*);
